// File: hw/rtl/scpf_pkg.sv
// ----------------------------------------------------------------------------
// scpf_pkg
// Shared types and constants of the sensor command packet framer.
// ----------------------------------------------------------------------------
package scpf_pkg;

    localparam int MAX_DATA    = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [7:0]  SYNC_HI    = 8'hEF;
    localparam logic [7:0]  SYNC_LO    = 8'h01;
    localparam logic [7:0]  CMD_ID     = 8'h01;
    localparam logic [31:0] ADDR_RESET = 32'hFFFF_FFFF;
    localparam logic [15:0] LEN_EXTRA  = 16'd3;

    localparam logic [3:0] STEP_SYNC_HI = 4'd0;
    localparam logic [3:0] STEP_SYNC_LO = 4'd1;
    localparam logic [3:0] STEP_ADDR3   = 4'd2;
    localparam logic [3:0] STEP_ADDR2   = 4'd3;
    localparam logic [3:0] STEP_ADDR1   = 4'd4;
    localparam logic [3:0] STEP_ADDR0   = 4'd5;
    localparam logic [3:0] STEP_IDENT   = 4'd6;
    localparam logic [3:0] STEP_LEN_HI  = 4'd7;
    localparam logic [3:0] STEP_LEN_LO  = 4'd8;
    localparam logic [3:0] STEP_BYTE    = 4'd9;
    localparam logic [3:0] STEP_SUM_HI  = 4'd10;
    localparam logic [3:0] STEP_SUM_LO  = 4'd11;

    typedef struct packed {
        logic        is_head;
        logic        add_cksum;
        logic [7:0]  byte_value;
        logic [7:0]  len_hi;
        logic [7:0]  len_lo;
        logic [15:0] sum;
    } req_t;

    typedef struct packed {
        logic valid;
        req_t req;
    } push_t;

    typedef struct packed {
        logic full;
        logic empty;
        req_t head;
    } queue_status_t;

endpackage

// File: hw/rtl/sensor_command_packet_framer_core.sv
// ----------------------------------------------------------------------------
// sensor_command_packet_framer_core
// Frames sensor command packets with a 16-bit additive checksum. A first
// request (is_first high) carries the instruction and data count and yields
// the 10-byte head, or 12 bytes with the checksum when the count is zero;
// each data request yields its byte, plus the two checksum bytes after the
// last one. Counts above MAX_DATA saturate, and data requests outside a
// packet are dropped. Requests enter at one per cycle while the 4-entry
// request queue has room; the output side sends one byte per cycle while
// tx_stall is low, and a packet head yields 10 or 12 bytes and each data
// request 1 or 3. The user writes device_address through cfg_write/cfg_data
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module sensor_command_packet_framer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [31:0] cfg_data,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        is_first,
    input  logic [7:0]  byte_value,
    input  logic [5:0]  data_count,
    output logic        tx_valid,
    input  logic        tx_stall,
    output logic [7:0]  tx_byte,
    output logic        end_of_packet
);
    import scpf_pkg::*;

    logic [31:0]   addr_reg;
    push_t         push;
    queue_status_t qstat;
    logic          pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            addr_reg <= ADDR_RESET;
        else if (cfg_write)
            addr_reg <= cfg_data;
    end

    scpf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .is_first   (is_first),
        .byte_value (byte_value),
        .data_count (data_count),
        .qstat      (qstat),
        .push       (push)
    );

    scpf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .qstat (qstat)
    );

    scpf_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .device_address (addr_reg),
        .qstat          (qstat),
        .pop            (pop),
        .tx_valid       (tx_valid),
        .tx_stall       (tx_stall),
        .tx_byte        (tx_byte),
        .end_of_packet  (end_of_packet)
    );

endmodule

// File: hw/rtl/scpf_front.sv
// ----------------------------------------------------------------------------
// scpf_front
// Accepts input items, tracks packet state and checksum, issues requests.
// ----------------------------------------------------------------------------
module scpf_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  logic                   is_first,
    input  logic [7:0]             byte_value,
    input  logic [5:0]             data_count,
    input  scpf_pkg::queue_status_t qstat,
    output scpf_pkg::push_t        push
);
    import scpf_pkg::*;

    logic [15:0] sum_reg, sum_next;
    logic [5:0]  remaining_reg, remaining_next;
    logic        in_packet_reg, in_packet_next;
    logic        accept;
    logic [5:0]  count_sat;
    logic [15:0] len;

    assign item_stall = qstat.full;
    assign accept     = item_valid && !qstat.full;

    always_comb
    begin
        if ({2'b00, data_count} > 8'(MAX_DATA))
            count_sat = 6'(MAX_DATA);
        else
            count_sat = data_count;
        len = 16'(count_sat) + LEN_EXTRA;
    end

    always_comb
    begin
        sum_next            = sum_reg;
        remaining_next      = remaining_reg;
        in_packet_next      = in_packet_reg;
        push.valid          = 1'b0;
        push.req.is_head    = is_first;
        push.req.add_cksum  = 1'b0;
        push.req.byte_value = byte_value;
        push.req.len_hi     = len[15:8];
        push.req.len_lo     = len[7:0];
        push.req.sum        = sum_reg;
        if (accept)
        begin
            if (is_first)
            begin
                sum_next = 16'(CMD_ID) + 16'(len[15:8]) + 16'(len[7:0]) + 16'(byte_value);
                remaining_next     = count_sat;
                in_packet_next     = (count_sat != 6'd0);
                push.valid         = 1'b1;
                push.req.add_cksum = (count_sat == 6'd0);
                push.req.sum       = sum_next;
            end
            else if (in_packet_reg && remaining_reg != 6'd0)
            begin
                sum_next           = sum_reg + 16'(byte_value);
                remaining_next     = remaining_reg - 6'd1;
                in_packet_next     = (remaining_reg != 6'd1);
                push.valid         = 1'b1;
                push.req.add_cksum = (remaining_reg == 6'd1);
                push.req.sum       = sum_next;
            end
            else
            begin
                // drop
                remaining_next = 6'd0;
                in_packet_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= 16'd0;
            remaining_reg <= 6'd0;
            in_packet_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            remaining_reg <= remaining_next;
            in_packet_reg <= in_packet_next;
        end
    end

endmodule

// File: hw/rtl/scpf_queue.sv
// ----------------------------------------------------------------------------
// scpf_queue
// Short request queue between the front and the back sequencer.
// ----------------------------------------------------------------------------
module scpf_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  scpf_pkg::push_t         push,
    input  logic                    pop,
    output scpf_pkg::queue_status_t qstat
);
    import scpf_pkg::*;

    req_t                entries [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg, count_next;

    assign qstat.full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign qstat.head  = entries[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push.valid && !pop)
            count_next = count_reg + 1'b1;
        else if (!push.valid && pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            entries[wr_ptr_reg] <= push.req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

// File: hw/rtl/scpf_back.sv
// ----------------------------------------------------------------------------
// scpf_back
// Byte sequencer: expands each request into packet bytes, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module scpf_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [31:0]             device_address,
    input  scpf_pkg::queue_status_t qstat,
    output logic                    pop,
    output logic                    tx_valid,
    input  logic                    tx_stall,
    output logic [7:0]              tx_byte,
    output logic                    end_of_packet
);
    import scpf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SEND = 2'b10
    } state_t;

    state_t      state_reg, state_next;
    req_t        cur_reg, cur_next;
    logic [3:0]  step_reg, step_next;
    logic [7:0]  byte_reg, byte_next;
    logic        eop_reg, eop_next;
    logic        valid_reg, valid_next;
    logic        advance;
    logic        emit;
    logic        last;
    req_t        req;
    logic [3:0]  step;
    logic [7:0]  sel_byte;

    assign advance = !valid_reg || !tx_stall;

    always_comb
    begin
        if (state_reg == ST_SEND)
        begin
            req = cur_reg;
            step = step_reg;
        end
        else
        begin
            req = qstat.head;
            step = qstat.head.is_head ? STEP_SYNC_HI : STEP_BYTE;
        end
        emit = advance && ((state_reg == ST_SEND) || !qstat.empty);
        pop  = advance && (state_reg == ST_IDLE) && !qstat.empty;
        last = (step == STEP_SUM_LO) || (step == STEP_BYTE && !req.add_cksum);
    end

    always_comb
    begin
        case (step)
            STEP_SYNC_HI: sel_byte = SYNC_HI;
            STEP_SYNC_LO: sel_byte = SYNC_LO;
            STEP_ADDR3:   sel_byte = device_address[31:24];
            STEP_ADDR2:   sel_byte = device_address[23:16];
            STEP_ADDR1:   sel_byte = device_address[15:8];
            STEP_ADDR0:   sel_byte = device_address[7:0];
            STEP_IDENT:   sel_byte = CMD_ID;
            STEP_LEN_HI:  sel_byte = req.len_hi;
            STEP_LEN_LO:  sel_byte = req.len_lo;
            STEP_BYTE:    sel_byte = req.byte_value;
            STEP_SUM_HI:  sel_byte = req.sum[15:8];
            STEP_SUM_LO:  sel_byte = req.sum[7:0];
            default:      sel_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        step_next  = step_reg;
        byte_next  = byte_reg;
        eop_next   = eop_reg;
        valid_next = valid_reg;
        if (emit)
        begin
            byte_next  = sel_byte;
            eop_next   = (step == STEP_SUM_LO);
            valid_next = 1'b1;
            cur_next   = req;
            step_next  = step + 4'd1;
            state_next = last ? ST_IDLE : ST_SEND;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        byte_reg <= byte_next;
        eop_reg  <= eop_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_SYNC_HI;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    assign tx_valid      = valid_reg;
    assign tx_byte       = byte_reg;
    assign end_of_packet = eop_reg;

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sensor command packet framer. A clocked driver
// feeds requests from a pending queue at the falling edge; a monitor at the
// rising edge predicts the framed bytes of every accepted request and checks
// each accepted output byte against the oldest expected one. The run steps
// through several device addresses and idle patterns, including a long
// output hold-off and a full drain pause on the input side.
// ----------------------------------------------------------------------------
module tb_top;

    import scpf_pkg::*;

    localparam int SETTLE     = 30;
    localparam int HOLD_AFTER = 250;
    localparam int HOLD_LEN   = 120;
    localparam int PAUSE_AT   = 150;
    localparam int LIMIT      = 200000;

    typedef struct packed {
        logic       first;
        logic [7:0] value;
        logic [5:0] count;
    } request_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [31:0] cfg_data = '0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic        is_first = 1'b0;
    logic [7:0]  byte_value = '0;
    logic [5:0]  data_count = '0;
    logic        tx_valid;
    logic        tx_stall = 1'b0;
    logic [7:0]  tx_byte;
    logic        end_of_packet;

    request_t    pending_q[$];
    frame_byte_t frame_q[$];
    frame_byte_t want_byte;

    logic [31:0] addr_shadow = ADDR_RESET;
    logic [15:0] sum_acc = '0;
    logic [5:0]  left_cnt = '0;
    logic        open_pkt = 1'b0;

    int idle_mode = 0;
    int n_offered = 0;
    int n_taken = 0;
    int n_results = 0;
    int n_packets = 0;
    int err_count = 0;
    int cycles = 0;
    int hold_left = 0;
    logic hold_seen = 1'b0;
    logic pause_seen = 1'b0;

    sensor_command_packet_framer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .is_first      (is_first),
        .byte_value    (byte_value),
        .data_count    (data_count),
        .tx_valid      (tx_valid),
        .tx_stall      (tx_stall),
        .tx_byte       (tx_byte),
        .end_of_packet (end_of_packet)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic logic roll(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic int sender_pct();
        return (idle_mode == 0) ? 31 : (idle_mode == 1) ? 45 : 0;
    endfunction

    function automatic int receiver_pct();
        return (idle_mode == 0) ? 45 : (idle_mode == 1) ? 31 : 0;
    endfunction

    task automatic push_byte(input logic [7:0] data, input logic last);
        frame_byte_t fb;
        begin
            fb.data = data;
            fb.last = last;
            frame_q.push_back(fb);
        end
    endtask

    task automatic push_checksum();
        begin
            push_byte(sum_acc[15:8], 1'b0);
            push_byte(sum_acc[7:0], 1'b1);
            open_pkt = 1'b0;
            left_cnt = '0;
        end
    endtask

    task automatic predict_request(input logic first, input logic [7:0] value,
                                   input logic [5:0] count);
        logic [5:0]  n;
        logic [15:0] len;
        begin
            if (first)
            begin
                n = (count > MAX_DATA) ? 6'(MAX_DATA) : count;
                len = {10'd0, n} + LEN_EXTRA;
                push_byte(SYNC_HI, 1'b0);
                push_byte(SYNC_LO, 1'b0);
                push_byte(addr_shadow[31:24], 1'b0);
                push_byte(addr_shadow[23:16], 1'b0);
                push_byte(addr_shadow[15:8], 1'b0);
                push_byte(addr_shadow[7:0], 1'b0);
                push_byte(CMD_ID, 1'b0);
                push_byte(len[15:8], 1'b0);
                push_byte(len[7:0], 1'b0);
                push_byte(value, 1'b0);
                sum_acc = {8'd0, CMD_ID} + {8'd0, len[15:8]} + {8'd0, len[7:0]}
                          + {8'd0, value};
                left_cnt = n;
                open_pkt = 1'b1;
                if (n == 0)
                    push_checksum();
            end
            else if (open_pkt && left_cnt != 0)
            begin
                push_byte(value, 1'b0);
                sum_acc = sum_acc + {8'd0, value};
                left_cnt = left_cnt - 6'd1;
                if (left_cnt == 0)
                    push_checksum();
            end
            else
            begin
                open_pkt = 1'b0;
                left_cnt = '0;
            end
        end
    endtask

    task automatic add_request(input logic first, input logic [7:0] value,
                               input logic [5:0] count);
        request_t rq;
        begin
            rq.first = first;
            rq.value = value;
            rq.count = count;
            pending_q.push_back(rq);
        end
    endtask

    task automatic gen_traffic(input int budget);
        int made;
        int pick;
        int sel;
        int cnt;
        int nbytes;
        begin
            made = 0;
            while (made < budget)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 90)
                begin
                    sel = $urandom_range(0, 99);
                    if (sel < 65)
                        cnt = $urandom_range(0, 6);
                    else if (sel < 92)
                        cnt = $urandom_range(7, 32);
                    else
                        cnt = $urandom_range(33, 63);
                    nbytes = (cnt > MAX_DATA) ? MAX_DATA : cnt;
                    if (pick >= 75 && nbytes != 0)
                        nbytes = $urandom_range(0, nbytes - 1);
                    add_request(1'b1, 8'($urandom_range(0, 255)), 6'(cnt));
                    repeat (nbytes)
                        add_request(1'b0, 8'($urandom_range(0, 255)),
                                    6'($urandom_range(0, 63)));
                    made += nbytes + 1;
                end
                else
                begin
                    nbytes = $urandom_range(1, 3);
                    repeat (nbytes)
                        add_request(1'b0, 8'($urandom_range(0, 255)),
                                    6'($urandom_range(0, 63)));
                    made += nbytes;
                end
            end
        end
    endtask

    task automatic wait_idle();
        begin
            while (pending_q.size() != 0 || item_valid || frame_q.size() != 0)
                @(posedge clk);
            repeat (SETTLE) @(posedge clk);
        end
    endtask

    task automatic write_address(input logic [31:0] value);
        begin
            @(negedge clk);
            cfg_write <= 1'b1;
            cfg_data  <= value;
            @(negedge clk);
            cfg_write <= 1'b0;
        end
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else if (item_valid && n_taken != n_offered)
            ;
        else if (n_offered == PAUSE_AT && !pause_seen)
        begin
            item_valid <= 1'b0;
            if (frame_q.size() == 0)
                pause_seen <= 1'b1;
        end
        else if (pending_q.size() == 0 || roll(sender_pct()))
            item_valid <= 1'b0;
        else
        begin
            {is_first, byte_value, data_count} <= pending_q.pop_front();
            item_valid <= 1'b1;
            n_offered  <= n_offered + 1;
        end
    end

    // output stall
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            tx_stall  <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_seen && n_results >= HOLD_AFTER)
        begin
            hold_seen <= 1'b1;
            hold_left <= HOLD_LEN;
            tx_stall  <= 1'b1;
        end
        else
            tx_stall <= roll(receiver_pct());
    end

    // prediction and check
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write)
                addr_shadow = cfg_data;
            if (item_valid && !item_stall)
            begin
                predict_request(is_first, byte_value, data_count);
                n_taken <= n_taken + 1;
            end
            if (tx_valid && !tx_stall)
            begin
                n_results <= n_results + 1;
                if (end_of_packet)
                    n_packets <= n_packets + 1;
                if (frame_q.size() == 0)
                begin
                    err_count = err_count + 1;
                    $error("unexpected output byte: tx_byte %h end_of_packet %b",
                           tx_byte, end_of_packet);
                end
                else
                begin
                    want_byte = frame_q.pop_front();
                    if (tx_byte !== want_byte.data)
                    begin
                        err_count = err_count + 1;
                        $error("tx_byte mismatch: expected %h, actual %h",
                               want_byte.data, tx_byte);
                    end
                    if (end_of_packet !== want_byte.last)
                    begin
                        err_count = err_count + 1;
                        $error("end_of_packet mismatch: expected %b, actual %b",
                               want_byte.last, end_of_packet);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        // empty packet, extreme instruction codes, stray data byte
        add_request(1'b1, 8'h00, 6'd0);
        add_request(1'b1, 8'hFF, 6'd1);
        add_request(1'b0, 8'hFF, 6'h3F);
        add_request(1'b0, 8'h55, 6'd0);
        // oversized count, then abandon the packet with a new first request
        add_request(1'b1, 8'h80, 6'h3F);
        add_request(1'b0, 8'hFF, 6'd0);
        add_request(1'b0, 8'h01, 6'h2A);
        add_request(1'b0, 8'h00, 6'h15);
        add_request(1'b1, 8'h7F, 6'd33);
        add_request(1'b1, 8'h01, 6'd2);
        add_request(1'b0, 8'h00, 6'd0);
        add_request(1'b0, 8'hFF, 6'h3F);
        add_request(1'b0, 8'hAA, 6'd5);
        add_request(1'b1, 8'h5A, 6'd32);
        add_request(1'b0, 8'hC3, 6'd0);
        add_request(1'b1, 8'hA5, 6'd0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait_idle();

        write_address(32'h0000_0000);
        gen_traffic(52);
        wait_idle();

        idle_mode = 1;
        write_address(32'hFFFF_FFFF);
        gen_traffic(52);
        wait_idle();

        idle_mode = 2;
        write_address($urandom());
        gen_traffic(48);
        wait_idle();

        write_address($urandom());
        gen_traffic(48);
        wait_idle();

        $display("covered %0d requests, %0d output bytes, %0d complete packets",
                 n_taken, n_results, n_packets);
        $display("under four device addresses, with output hold-off and input drain");
        if (err_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
